>>> rtl/core/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg
// Types, character codes and the single-byte lexing function shared by the
// subtitle line lexer modules.
// ----------------------------------------------------------------------------
package sll_pkg;

  typedef enum logic [9:0] {
    ST_START = 10'b00_0000_0001,
    ST_BOM0  = 10'b00_0000_0010,
    ST_BOM1  = 10'b00_0000_0100,
    ST_KW0   = 10'b00_0000_1000,
    ST_KW1   = 10'b00_0001_0000,
    ST_KW2   = 10'b00_0010_0000,
    ST_KW3   = 10'b00_0100_0000,
    ST_KW4   = 10'b00_1000_0000,
    ST_CR    = 10'b01_0000_0000,
    ST_SPACE = 10'b10_0000_0000
  } lex_state_t;

  localparam logic [2:0] TK_NEWLINE = 3'd0;
  localparam logic [2:0] TK_SPACE   = 3'd1;
  localparam logic [2:0] TK_KEYWORD = 3'd2;
  localparam logic [2:0] TK_BOM     = 3'd3;
  localparam logic [2:0] TK_BAD     = 3'd4;

  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam logic [7:0] CH_BOM0 = 8'hEF;
  localparam logic [7:0] CH_BOM1 = 8'hBB;
  localparam logic [7:0] CH_BOM2 = 8'hBF;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_W    = 8'h57;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_V    = 8'h56;
  localparam logic [7:0] CH_T    = 8'h54;

  localparam logic [1:0] BYTES_MAX = 2'd3;
  localparam logic [1:0] BOM_LEAD  = 2'd2;

  // result queue depth and the matching level width
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_LW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    lex_state_t  st;
    logic [31:0] line;
    logic [31:0] col;
    logic [1:0]  bytes;
  } lex_ctx_t;

  typedef struct packed {
    lex_ctx_t   ctx;
    logic       emit;
    logic [2:0] kind;
    logic [7:0] bad;
    logic       again;
    logic       clr_tl;
  } lex_res_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] line;
    logic [31:0] col;
    logic [7:0]  bad;
    logic        last;
  } tok_t;

  typedef struct packed {
    tok_t       tok0;
    tok_t       tok1;
    logic [1:0] cnt;
    logic       at_start;
  } core_out_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // One pass over a data byte from the given context.
  function automatic lex_res_t lex_byte(input lex_ctx_t cur, input logic [7:0] c,
                                        input logic space_full);
    lex_res_t r;
    logic     mismatch;
    logic     is_blank;
    r          = '0;
    r.ctx      = cur;
    r.ctx.col  = sat_inc(cur.col);
    r.ctx.bytes = (cur.bytes == BYTES_MAX) ? BYTES_MAX : cur.bytes + 2'd1;
    r.kind     = TK_BAD;
    mismatch   = 1'b0;
    is_blank   = (c == CH_SP) || (c == CH_TAB);
    case (cur.st)
      ST_START: begin
        if (c == CH_W) begin
          r.ctx.st = ST_KW0;
        end else if (c == CH_BOM0) begin
          r.ctx.st = ST_BOM0;
        end else if (c == CH_LF) begin
          r.ctx.line = sat_inc(cur.line);
          r.ctx.col  = 32'd1;
          r.emit     = 1'b1;
          r.kind     = TK_NEWLINE;
        end else if (c == CH_CR) begin
          r.ctx.st = ST_CR;
        end else if (is_blank) begin
          r.ctx.st = ST_SPACE;
        end else begin
          mismatch = 1'b1;
        end
      end
      ST_BOM0: begin
        if (c == CH_BOM1) r.ctx.st = ST_BOM1;
        else mismatch = 1'b1;
      end
      ST_BOM1: begin
        if (c == CH_BOM2) begin
          if (cur.bytes == BOM_LEAD) begin
            // leading mark: drop it and restart the position
            r.ctx.col   = 32'd1;
            r.ctx.bytes = 2'd0;
            r.ctx.st    = ST_START;
            r.clr_tl    = 1'b1;
          end else begin
            r.emit = 1'b1;
            r.kind = TK_BOM;
          end
        end else begin
          mismatch = 1'b1;
        end
      end
      ST_KW0: begin
        if (c == CH_E) r.ctx.st = ST_KW1;
        else mismatch = 1'b1;
      end
      ST_KW1: begin
        if (c == CH_B) r.ctx.st = ST_KW2;
        else mismatch = 1'b1;
      end
      ST_KW2: begin
        if (c == CH_V) r.ctx.st = ST_KW3;
        else mismatch = 1'b1;
      end
      ST_KW3: begin
        if (c == CH_T) r.ctx.st = ST_KW4;
        else mismatch = 1'b1;
      end
      ST_KW4: begin
        if (c == CH_T) begin
          r.emit = 1'b1;
          r.kind = TK_KEYWORD;
        end else begin
          mismatch = 1'b1;
        end
      end
      ST_CR: begin
        r.again    = (c != CH_LF);
        r.ctx.line = sat_inc(cur.line);
        r.ctx.col  = 32'd1;
        r.emit     = 1'b1;
        r.kind     = TK_NEWLINE;
      end
      ST_SPACE: begin
        if (is_blank) begin
          if (space_full) begin
            r.emit = 1'b1;
            r.kind = TK_SPACE;
          end
        end else begin
          // push the byte back: undo its column step
          r.ctx.col = cur.col;
          r.again   = 1'b1;
          r.emit    = 1'b1;
          r.kind    = TK_SPACE;
        end
      end
      default: begin
        mismatch = 1'b1;
      end
    endcase
    if (mismatch) begin
      r.ctx.col = cur.col;
      r.emit    = 1'b1;
      r.kind    = TK_BAD;
      r.bad     = c;
    end
    if (r.emit) begin
      r.ctx.st = ST_START;
      r.clr_tl = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/subtitle_line_lexer.sv
// ----------------------------------------------------------------------------
// subtitle_line_lexer
// Byte tokenizer for a subtitle text header: newlines, blank runs, the
// WEBVTT keyword, byte order marks and bad tokens, with line and column.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_req_type, in_byte_value
//   out_     out  out_valid/out_ready  out_token_kind, out_line_number,
//                                      out_column_number, out_bad_byte,
//                                      out_last_of_run
//
// One item a cycle while the result queue has room: an item is held in the
// input register, where the lexer pass (two passes for a pushed-back byte)
// runs into a four-entry result queue. An item may yield two tokens; the
// output port delivers one token per cycle while out_ready is high, so such
// items drain at the output rate. Reset returns the lexer to the start
// state, line 1, column 1, and empties the queue. An item waits in the input
// register until the queue has room for all its tokens.
// ----------------------------------------------------------------------------
module subtitle_line_lexer #(
  parameter int unsigned TOKEN_CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_kind,
  output logic [31:0] out_line_number,
  output logic [31:0] out_column_number,
  output logic [7:0]  out_bad_byte,
  output logic        out_last_of_run
);

  localparam int unsigned LW = sll_pkg::OQ_LW;

  logic               in_vld_r, in_vld_nxt;
  logic               in_req_r;
  logic [7:0]         in_byte_r;
  logic               consume;
  logic               pop;
  logic [LW-1:0]      level;
  logic [1:0]         push_cnt;
  sll_pkg::core_out_t core_res;
  sll_pkg::tok_t      head;

  // hold the item until every token it makes fits without counting pops
  assign consume  = in_vld_r &&
                    ((LW + 1)'(level) + (LW + 1)'(core_res.cnt) <=
                     (LW + 1)'(sll_pkg::OQ_DEPTH));
  assign in_ready = !in_vld_r || consume;
  assign push_cnt = consume ? core_res.cnt : 2'd0;
  assign pop      = out_valid && out_ready;
  assign in_vld_nxt = in_valid ? 1'b1 : (in_vld_r && !consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_r  <= in_req_type;
      in_byte_r <= in_byte_value;
    end
  end

  sll_lex_core #(
    .TOKEN_CAPACITY(TOKEN_CAPACITY)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_type   (in_req_r),
    .byte_value (in_byte_r),
    .commit     (consume),
    .res        (core_res)
  );

  sll_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .tok0     (core_res.tok0),
    .tok1     (core_res.tok1),
    .pop      (pop),
    .level    (level),
    .head     (head)
  );

  assign out_valid         = (level != '0);
  assign out_token_kind    = head.kind;
  assign out_line_number   = head.line;
  assign out_column_number = head.col;
  assign out_bad_byte      = head.bad;
  assign out_last_of_run   = head.last;

  // a second token only follows a pushed-back CR or blank run
  a_pair_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && core_res.cnt == 2'd2) |->
      (core_res.tok0.kind == sll_pkg::TK_NEWLINE ||
       core_res.tok0.kind == sll_pkg::TK_SPACE) && !core_res.tok0.last)
    else $error("two-token item with unexpected first token");

  // end of input in the start state yields nothing
  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && in_req_r == sll_pkg::REQ_FINISH && core_res.at_start) |->
      core_res.cnt == 2'd0)
    else $error("end of input in start state produced a token");

  // queue level moves by exactly pushes minus pops
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (level == $past(level) + LW'($past(push_cnt)) - LW'($past(pop))))
    else $error("result queue level mismatch");

endmodule

>>> rtl/core/sll_lex_core.sv
// ----------------------------------------------------------------------------
// sll_lex_core
// Lexer state registers and next-state logic for one item: a byte gets one
// pass, a second from the start state if pushed back; finish ends any token.
// ----------------------------------------------------------------------------
module sll_lex_core #(
  parameter int unsigned TOKEN_CAPACITY = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_type,
  input  logic [7:0]            byte_value,
  input  logic                  commit,
  output sll_pkg::core_out_t    res
);

  localparam int unsigned TLW = $clog2(TOKEN_CAPACITY);
  localparam logic [TLW-1:0] FULL_AT = TLW'(TOKEN_CAPACITY - 2);

  sll_pkg::lex_ctx_t ctx_r, ctx_nxt;
  logic [TLW-1:0]    tl_r, tl_nxt;

  sll_pkg::lex_res_t p1, p2;
  sll_pkg::lex_ctx_t eoi_ctx;
  logic [2:0]        eoi_kind;
  logic              two;
  sll_pkg::tok_t     t_p1, t_p2, t_eoi;

  always_comb begin
    p1 = sll_pkg::lex_byte(ctx_r, byte_value, tl_r >= FULL_AT);
    // a pushed-back byte always restarts from the start state with no run
    p2 = sll_pkg::lex_byte(p1.ctx, byte_value, 1'b0);

    eoi_ctx    = ctx_r;
    eoi_ctx.st = sll_pkg::ST_START;
    eoi_kind   = sll_pkg::TK_SPACE;
    if (ctx_r.st != sll_pkg::ST_SPACE) begin
      eoi_ctx.col   = 32'd1;
      eoi_ctx.bytes = 2'd0;
      eoi_kind      = sll_pkg::TK_BAD;
    end

    two   = p1.again && p2.emit;
    t_p1  = '{kind: p1.kind, line: p1.ctx.line, col: p1.ctx.col, bad: p1.bad, last: !two};
    t_p2  = '{kind: p2.kind, line: p2.ctx.line, col: p2.ctx.col, bad: p2.bad, last: 1'b1};
    t_eoi = '{kind: eoi_kind, line: eoi_ctx.line, col: eoi_ctx.col, bad: 8'd0, last: 1'b1};

    res.at_start = (ctx_r.st == sll_pkg::ST_START);
    res.tok1     = t_p2;
    if (req_type == sll_pkg::REQ_FINISH) begin
      res.tok0 = t_eoi;
      res.cnt  = res.at_start ? 2'd0 : 2'd1;
      ctx_nxt  = res.at_start ? ctx_r : eoi_ctx;
      tl_nxt   = '0;
    end else begin
      res.tok0 = t_p1;
      res.cnt  = two ? 2'd2 : {1'b0, p1.emit};
      if (p1.again) begin
        ctx_nxt = p2.ctx;
        tl_nxt  = p2.clr_tl ? '0 : TLW'(1);
      end else begin
        ctx_nxt = p1.ctx;
        tl_nxt  = p1.clr_tl ? '0 : tl_r + TLW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.st    <= sll_pkg::ST_START;
      ctx_r.line  <= 32'd1;
      ctx_r.col   <= 32'd1;
      ctx_r.bytes <= 2'd0;
      tl_r        <= '0;
    end else if (commit) begin
      ctx_r <= ctx_nxt;
      tl_r  <= tl_nxt;
    end
  end

endmodule

>>> rtl/core/sll_out_fifo.sv
// ----------------------------------------------------------------------------
// sll_out_fifo
// Small result queue: takes up to two tokens a cycle, delivers one a cycle on pop.
// ----------------------------------------------------------------------------
module sll_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    push_cnt,
  input  sll_pkg::tok_t                 tok0,
  input  sll_pkg::tok_t                 tok1,
  input  logic                          pop,
  output logic [sll_pkg::OQ_LW-1:0]     level,
  output sll_pkg::tok_t                 head
);

  localparam int unsigned AW = sll_pkg::OQ_AW;
  localparam int unsigned LW = sll_pkg::OQ_LW;

  sll_pkg::tok_t mem [sll_pkg::OQ_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    level_nxt  = level_r + LW'(push_cnt) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_ptr_r] <= tok0;
    if (push_cnt == 2'd2) mem[wr_ptr_r + AW'(1)] <= tok1;
  end

  assign level = level_r;
  assign head  = mem[rd_ptr_r];

endmodule
